### rtl/binary_morph_3x3_bitpacked_assert.svh
// ----------------------------------------------------------------------------
// binary morphology assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BINARY_MORPH_3X3_BITPACKED_ASSERT_SVH
`define BINARY_MORPH_3X3_BITPACKED_ASSERT_SVH

// same-cycle implication, off during reset
`define BM3_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bm3 assertion failed");

// next-cycle implication, off during reset
`define BM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bm3 assertion failed");

// next-cycle implication, always on
`define BM3_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bm3 assertion failed");

`endif

### rtl/bm3_pkg.sv
// ----------------------------------------------------------------------------
// bm3_pkg
// types, constants and helpers of the packed binary morphology block
// ----------------------------------------------------------------------------
`default_nettype none

package bm3_pkg;

    localparam int WORD_BITS  = 32;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int NUM_STAGES = 5;
    localparam int NUM_ROWS   = 3;
    localparam int MAX_WPR    = MAX_WIDTH / WORD_BITS;
    localparam int COL_W      = $clog2(MAX_WPR);
    localparam int WPR_W      = $clog2(MAX_WPR + 1);
    localparam int DIM_W      = 9;
    localparam int MODE_W     = 3;
    localparam int REM_W      = $clog2(WORD_BITS);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int IROW_W     = ROW_W + 1;
    localparam int IDX_W      = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DIM_W-1:0]  RST_WIDTH  = DIM_W'(188);
    localparam logic [DIM_W-1:0]  RST_HEIGHT = DIM_W'(120);

    localparam logic [MODE_W-1:0] MODE_ERODE      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DILATE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OPEN_CLOSE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GRADIENT   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    typedef enum logic [1:0] {
        OP_ERODE,
        OP_DILATE,
        OP_GRAD,
        OP_PASS
    } t_op;

    typedef struct packed {
        logic [WPR_W-1:0]  wpr;
        logic [DIM_W-1:0]  height;
        logic [REM_W-1:0]  rem;
        logic [MODE_W-1:0] mode;
    } t_cfg;

    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic [WORD_BITS-1:0] word;
        t_cfg                 cfg;
    } t_beat;

    typedef logic [NUM_ROWS-1:0][WORD_BITS-1:0] t_col;

    function automatic logic [WORD_BITS-1:0] tail_mask(input logic [REM_W-1:0] rem);
        logic [WORD_BITS-1:0] m;
        m = (rem == '0) ? '1 : ((WORD_BITS'(1) << rem) - WORD_BITS'(1));
        return m;
    endfunction

    function automatic t_cfg make_cfg(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                      input logic [MODE_W-1:0] m);
        t_cfg             c;
        logic [DIM_W-1:0] wc;
        logic [DIM_W:0]   sum;
        wc = w;
        if (w == '0) wc = DIM_W'(1);
        if (w > DIM_W'(MAX_WIDTH)) wc = DIM_W'(MAX_WIDTH);
        sum = {1'b0, wc} + (DIM_W+1)'(WORD_BITS - 1);
        c.wpr = WPR_W'(sum >> REM_W);
        c.rem = wc[REM_W-1:0];
        c.height = h;
        if (h == '0) c.height = DIM_W'(1);
        if (h > DIM_W'(MAX_HEIGHT)) c.height = DIM_W'(MAX_HEIGHT);
        c.mode = (m > MODE_GRADIENT) ? MODE_GRADIENT : m;
        return c;
    endfunction

    function automatic t_op stage_op(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx);
        t_op op;
        op = OP_PASS;
        unique case (mode)
            MODE_ERODE: begin
                if (idx == 3'd0) op = OP_ERODE;
            end
            MODE_DILATE: begin
                if (idx == 3'd0) op = OP_DILATE;
            end
            MODE_CLOSE: begin
                if (idx == 3'd0) op = OP_DILATE;
                else if (idx == 3'd1) op = OP_ERODE;
            end
            default: begin
                if (idx == 3'd0 || idx == 3'd3) op = OP_ERODE;
                else if (idx == 3'd1 || idx == 3'd2) op = OP_DILATE;
                else if (idx == 3'd4 && mode == MODE_GRADIENT) op = OP_GRAD;
            end
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

### rtl/bm3_in_if.sv
// ----------------------------------------------------------------------------
// bm3_in_if
// input word channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface bm3_in_if import bm3_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] pixel_word;
    logic                 frame_start;

    modport source (output valid, output pixel_word, output frame_start, input ready);
    modport sink   (input valid, input pixel_word, input frame_start, output ready);
endinterface

`default_nettype wire

### rtl/bm3_out_if.sv
// ----------------------------------------------------------------------------
// bm3_out_if
// result word channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface bm3_out_if import bm3_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] out_word;
    logic                 out_last;

    modport source (output valid, output out_word, output out_last, input ready);
    modport sink   (input valid, input out_word, input out_last, output ready);
endinterface

`default_nettype wire

### rtl/bm3_front.sv
// ----------------------------------------------------------------------------
// bm3_front
// input position tracking, frame settings latch and tail masking
// ----------------------------------------------------------------------------
`default_nettype none

module bm3_front import bm3_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire logic                 i_valid,
    input  wire logic [WORD_BITS-1:0] i_word,
    input  wire logic                 i_frame_start,
    input  wire logic [DIM_W-1:0]     i_width,
    input  wire logic [DIM_W-1:0]     i_height,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic                 i_last_done,
    output logic                      o_ready,
    output t_beat                     o_beat
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_hold, n_hold;
    t_cfg             r_cfg;
    t_beat            r_beat;

    logic             accept;
    logic             first;
    t_cfg             cfg;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             lastcol;
    logic             last;

    assign o_ready = i_adv && !r_hold;
    assign accept  = i_valid && o_ready;
    assign first   = i_frame_start || (r_row == '0 && r_col == '0);
    assign cfg     = first ? make_cfg(i_width, i_height, i_mode) : r_cfg;
    assign col     = first ? '0 : r_col;
    assign row     = first ? '0 : r_row;
    assign lastcol = (WPR_W'(col) == cfg.wpr - WPR_W'(1));
    assign last    = lastcol && (DIM_W'(row) == cfg.height - DIM_W'(1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_hold = r_hold;
        if (accept) begin
            if (last) begin
                n_col = '0;
                n_row = '0;
                n_hold = 1'b1;
            end else if (lastcol) begin
                n_col = '0;
                n_row = row + ROW_W'(1);
            end else begin
                n_col = col + COL_W'(1);
                n_row = row;
            end
        end
        if (i_last_done) n_hold = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_hold <= 1'b0;
            r_beat.valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_hold <= n_hold;
            if (i_adv) r_beat.valid <= accept;
        end
        if (accept) r_cfg <= cfg;
        if (i_adv) begin
            r_beat.first <= first;
            r_beat.last <= last;
            r_beat.word <= lastcol ? (i_word & tail_mask(cfg.rem)) : i_word;
            r_beat.cfg <= cfg;
        end
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

### rtl/bm3_lane.sv
// ----------------------------------------------------------------------------
// bm3_lane
// one window row: horizontal 3-tap and/or across a packed word
// ----------------------------------------------------------------------------
`default_nettype none

module bm3_lane import bm3_pkg::*; (
    input  wire logic                 i_dilate,
    input  wire logic [WORD_BITS-1:0] i_left,
    input  wire logic [WORD_BITS-1:0] i_ctr,
    input  wire logic [WORD_BITS-1:0] i_right,
    output logic      [WORD_BITS-1:0] o_row
);

    logic [WORD_BITS-1:0] shl;
    logic [WORD_BITS-1:0] shr;

    assign shl   = (i_ctr << 1) | (i_left >> (WORD_BITS - 1));
    assign shr   = (i_ctr >> 1) | (i_right << (WORD_BITS - 1));
    assign o_row = i_dilate ? (shl | i_ctr | shr) : (shl & i_ctr & shr);

endmodule

`default_nettype wire

### rtl/bm3_stage.sv
// ----------------------------------------------------------------------------
// bm3_stage
// one 3x3 stage: two line stores, column window, three row lanes and merge
// ----------------------------------------------------------------------------
`default_nettype none

module bm3_stage import bm3_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire t_beat            i_beat,
    output t_beat                 o_beat
);

    logic [WORD_BITS-1:0] mem_prev [MAX_WPR];
    logic [WORD_BITS-1:0] mem_prev2 [MAX_WPR];

    logic [IROW_W-1:0] r_ir, n_ir;
    logic [COL_W-1:0]  r_ic, n_ic;
    logic [ROW_W-1:0]  r_orow, n_orow;
    logic [COL_W-1:0]  r_ocol, n_ocol;
    logic              r_flush, n_flush;
    t_cfg              r_cfg;
    t_col              r_v1, r_v2;
    t_beat             r_out;

    t_cfg                 cfg;
    t_op                  op;
    logic                 pass;
    logic                 act;
    logic [WORD_BITS-1:0] x;
    logic [IROW_W-1:0]    ir;
    logic [COL_W-1:0]     ic;
    logic [ROW_W-1:0]     orow;
    logic [COL_W-1:0]     ocol;
    t_col                 v_n;
    logic                 emit;
    logic                 final_pos;
    logic                 left_ok, right_ok;
    logic [NUM_ROWS-1:0]  row_ok;
    logic [NUM_ROWS-1:0][WORD_BITS-1:0] lane_l, lane_r, lane_c, lane_o;
    logic [WORD_BITS-1:0] acc;
    logic [WORD_BITS-1:0] result;

    assign cfg   = i_beat.valid ? i_beat.cfg : r_cfg;
    assign op    = stage_op(cfg.mode, i_idx);
    assign pass  = (op == OP_PASS);
    assign act   = i_beat.valid || r_flush;
    assign x     = i_beat.valid ? i_beat.word : '0;
    assign ir    = (i_beat.valid && i_beat.first) ? '0 : r_ir;
    assign ic    = (i_beat.valid && i_beat.first) ? '0 : r_ic;
    assign orow  = (i_beat.valid && i_beat.first) ? '0 : r_orow;
    assign ocol  = (i_beat.valid && i_beat.first) ? '0 : r_ocol;

    assign v_n[0] = mem_prev2[ic];
    assign v_n[1] = mem_prev[ic];
    assign v_n[2] = x;

    assign emit = act && !pass && (ir >= IROW_W'(2) || (ir == IROW_W'(1) && ic != '0));
    assign final_pos = (DIM_W'(orow) == cfg.height - DIM_W'(1))
                    && (WPR_W'(ocol) == cfg.wpr - WPR_W'(1));

    assign left_ok  = (ocol != '0);
    assign right_ok = (WPR_W'(ocol) != cfg.wpr - WPR_W'(1));
    assign row_ok[0] = (orow != '0);
    assign row_ok[1] = 1'b1;
    assign row_ok[2] = (DIM_W'(orow) != cfg.height - DIM_W'(1));

    for (genvar g = 0; g < NUM_ROWS; g++) begin : g_lane
        assign lane_l[g] = r_v2[g] & {WORD_BITS{left_ok && row_ok[g]}};
        assign lane_c[g] = r_v1[g] & {WORD_BITS{row_ok[g]}};
        assign lane_r[g] = v_n[g] & {WORD_BITS{right_ok && row_ok[g]}};
        bm3_lane u_lane (
            .i_dilate (op == OP_DILATE),
            .i_left   (lane_l[g]),
            .i_ctr    (lane_c[g]),
            .i_right  (lane_r[g]),
            .o_row    (lane_o[g])
        );
    end

    always_comb begin
        if (op == OP_DILATE) acc = lane_o[0] | lane_o[1] | lane_o[2];
        else acc = lane_o[0] & lane_o[1] & lane_o[2];
        if (!right_ok) acc = acc & tail_mask(cfg.rem);
        result = (op == OP_GRAD) ? (r_v1[1] & ~acc) : acc;
    end

    always_comb begin
        n_ir = r_ir;
        n_ic = r_ic;
        n_orow = r_orow;
        n_ocol = r_ocol;
        n_flush = r_flush;
        if (act && !pass) begin
            if (WPR_W'(ic) == cfg.wpr - WPR_W'(1)) begin
                n_ic = '0;
                n_ir = ir + IROW_W'(1);
            end else begin
                n_ic = ic + COL_W'(1);
                n_ir = ir;
            end
            n_orow = orow;
            n_ocol = ocol;
            if (emit) begin
                if (!right_ok) begin
                    n_ocol = '0;
                    n_orow = orow + ROW_W'(1);
                end else begin
                    n_ocol = ocol + COL_W'(1);
                end
            end
            if (emit && final_pos) n_flush = 1'b0;
            else if (i_beat.valid && i_beat.last) n_flush = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir <= '0;
            r_ic <= '0;
            r_orow <= '0;
            r_ocol <= '0;
            r_flush <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (i_adv) begin
            r_ir <= n_ir;
            r_ic <= n_ic;
            r_orow <= n_orow;
            r_ocol <= n_ocol;
            r_flush <= n_flush;
            r_out.valid <= pass ? i_beat.valid : emit;
        end
        if (i_adv) begin
            if (i_beat.valid) r_cfg <= i_beat.cfg;
            if (act && !pass) begin
                mem_prev[ic] <= x;
                mem_prev2[ic] <= v_n[1];
                r_v1 <= v_n;
                r_v2 <= r_v1;
            end
            if (pass) begin
                r_out.first <= i_beat.first;
                r_out.last <= i_beat.last;
                r_out.word <= i_beat.word;
                r_out.cfg <= i_beat.cfg;
            end else begin
                r_out.first <= (orow == '0 && ocol == '0);
                r_out.last <= final_pos;
                r_out.word <= result;
                r_out.cfg <= cfg;
            end
        end
    end

    assign o_beat = r_out;

endmodule

`default_nettype wire

### rtl/binary_morph_3x3_bitpacked.sv
// ----------------------------------------------------------------------------
// binary_morph_3x3_bitpacked
// streaming 3x3 erode/dilate/close/open-close/gradient on 32-pixel packed words
// ----------------------------------------------------------------------------
// channel   dir  payload                  transaction
// i_in      in   pixel_word, frame_start  valid && ready
// o_out     out  out_word, out_last       valid && ready
// i_cfg_*   in   idx, data                i_cfg_we
//
// one word per cycle inside a frame; each active 3x3 stage lags by one row
// plus one word, plus one register per stage (six stages incl. front)
// after a frame's last word input is held off until out_last is taken, while each
// active stage flushes its last row plus one word of results
// sync active-low reset; no clearing pass; stalls freeze the whole chain
// ----------------------------------------------------------------------------
`default_nettype none

module binary_morph_3x3_bitpacked import bm3_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    bm3_in_if.sink                    i_in,
    bm3_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DIM_W-1:0]     i_cfg_data
);

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [MODE_W-1:0] r_mode;

    logic  adv;
    logic  last_done;
    t_beat beat [NUM_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_mode <= MODE_OPEN_CLOSE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_width <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_MODE:   r_mode <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv       = !beat[NUM_STAGES].valid || o_out.ready;
    assign last_done = o_out.valid && o_out.ready && o_out.out_last;

    bm3_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_valid       (i_in.valid),
        .i_word        (i_in.pixel_word),
        .i_frame_start (i_in.frame_start),
        .i_width       (r_width),
        .i_height      (r_height),
        .i_mode        (r_mode),
        .i_last_done   (last_done),
        .o_ready       (i_in.ready),
        .o_beat        (beat[0])
    );

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        bm3_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_idx   (IDX_W'(g)),
            .i_beat  (beat[g]),
            .o_beat  (beat[g+1])
        );
    end

    assign o_out.valid    = beat[NUM_STAGES].valid;
    assign o_out.out_word = beat[NUM_STAGES].word;
    assign o_out.out_last = beat[NUM_STAGES].last;

endmodule

`default_nettype wire

### rtl/bm3_chk.sv
// ----------------------------------------------------------------------------
// bm3_chk
// port-level checker bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_morph_3x3_bitpacked_assert.svh"

module bm3_chk import bm3_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [WORD_BITS-1:0] i_out_word,
    input wire logic                 i_out_last
);

    `BM3_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `BM3_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_word) && $stable(i_out_last))
    `BM3_ASSERT_IMPLY(a_in_needs_room, i_clk, i_rst_n, i_in_ready && i_in_valid, !i_out_valid || i_out_ready)
    `BM3_ASSERT_ALWAYS_NEXT(a_reset_quiet, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind binary_morph_3x3_bitpacked bm3_chk u_bm3_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.out_word),
    .i_out_last  (o_out.out_last)
);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// frame-level check of the packed 3x3 binary morphology stream
// ----------------------------------------------------------------------------
// frames of random size, mode and pixel density are pushed through the input
// channel while both channels idle at random; a line-store predictor of the
// erode/dilate chain computes every result word and out_last, and the monitor
// compares them in order. settings change between frames only, with the
// extremes, saturated values and dropped partial frames among them
// ----------------------------------------------------------------------------
module tb;
    import bm3_pkg::*;

    typedef struct {
        logic [WORD_BITS-1:0] word;
        logic                 start;
    } t_pix_item;

    typedef struct {
        logic [WORD_BITS-1:0] word;
        logic                 last;
    } t_res_item;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DIM_W-1:0]     i_cfg_data;

    bm3_in_if  in_ch ();
    bm3_out_if out_ch ();

    binary_morph_3x3_bitpacked u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_pix_item pixel_queue[$];
    t_res_item result_queue[$];

    int err_count;
    int words_sent;
    int words_checked;
    int frames_sent;
    int in_gap;
    int out_gap;
    int out_hold_cycles;
    bit no_idle;

    // settings as written to the block
    logic [DIM_W-1:0]  reg_width;
    logic [DIM_W-1:0]  reg_height;
    logic [MODE_W-1:0] reg_mode;

    // settings latched for the running frame
    int unsigned          fr_wpr;
    int unsigned          fr_height;
    int unsigned          fr_total;
    logic [WORD_BITS-1:0] fr_tail;
    int unsigned          fr_stages;
    t_op                  fr_ops[NUM_STAGES];

    logic [WORD_BITS-1:0] row_ring[NUM_STAGES][32];
    int unsigned          words_in[NUM_STAGES];
    int unsigned          words_out[NUM_STAGES];
    int unsigned          pos_col;
    int unsigned          pos_row;

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void latch_frame();
        int unsigned w, h;
        logic [MODE_W-1:0] m;
        w = reg_width;
        h = reg_height;
        m = reg_mode;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        if (m > MODE_GRADIENT) m = MODE_GRADIENT;
        fr_wpr = (w + WORD_BITS - 1) / WORD_BITS;
        fr_height = h;
        fr_total = fr_wpr * h;
        fr_tail = (w % WORD_BITS != 0) ? ((32'd1 << (w % WORD_BITS)) - 32'd1) : '1;
        case (m)
            MODE_ERODE: begin
                fr_stages = 1;
                fr_ops[0] = OP_ERODE;
            end
            MODE_DILATE: begin
                fr_stages = 1;
                fr_ops[0] = OP_DILATE;
            end
            MODE_CLOSE: begin
                fr_stages = 2;
                fr_ops[0] = OP_DILATE;
                fr_ops[1] = OP_ERODE;
            end
            default: begin
                fr_ops[0] = OP_ERODE;
                fr_ops[1] = OP_DILATE;
                fr_ops[2] = OP_DILATE;
                fr_ops[3] = OP_ERODE;
                fr_ops[4] = OP_GRAD;
                fr_stages = (m == MODE_OPEN_CLOSE) ? 4 : 5;
            end
        endcase
        for (int s = 0; s < NUM_STAGES; s++) begin
            words_in[s] = 0;
            words_out[s] = 0;
            for (int k = 0; k < 32; k++) row_ring[s][k] = '0;
        end
        pos_col = 0;
        pos_row = 0;
    endfunction

    function automatic logic [WORD_BITS-1:0] neighbor(int s, int rr, int cc);
        if (rr < 0 || rr >= int'(fr_height) || cc < 0 || cc >= int'(fr_wpr)) return '0;
        return row_ring[s][(rr * fr_wpr + cc) % 32];
    endfunction

    function automatic logic [WORD_BITS-1:0] window_word(int s, int unsigned p);
        int r, c;
        logic [WORD_BITS-1:0] acc, lw, cw, rw, sl, sr;
        bit grow;
        r = p / fr_wpr;
        c = p % fr_wpr;
        grow = (fr_ops[s] == OP_DILATE);
        acc = grow ? '0 : '1;
        for (int dr = -1; dr <= 1; dr++) begin
            lw = neighbor(s, r + dr, c - 1);
            cw = neighbor(s, r + dr, c);
            rw = neighbor(s, r + dr, c + 1);
            sl = (cw << 1) | (lw >> 31);
            sr = (cw >> 1) | (rw << 31);
            if (grow) acc |= sl | cw | sr;
            else acc &= sl & cw & sr;
        end
        if (c == int'(fr_wpr) - 1) acc &= fr_tail;
        if (fr_ops[s] == OP_GRAD) acc = neighbor(s, r, c) & ~acc;
        return acc;
    endfunction

    function automatic void predict_words(logic [WORD_BITS-1:0] word, logic start);
        logic [WORD_BITS-1:0] stage_in[$];
        logic [WORD_BITS-1:0] stage_out[$];
        t_res_item res;
        bit last;
        int unsigned n;
        if (start || (pos_row == 0 && pos_col == 0)) latch_frame();
        if (pos_col == fr_wpr - 1) word &= fr_tail;
        last = (pos_row == fr_height - 1) && (pos_col == fr_wpr - 1);
        pos_col++;
        if (pos_col >= fr_wpr) begin
            pos_col = 0;
            pos_row = (pos_row + 1) & 8'hFF;
        end
        if (last) begin
            pos_row = 0;
            pos_col = 0;
        end
        stage_in.push_back(word);
        for (int s = 0; s < int'(fr_stages); s++) begin
            stage_out.delete();
            foreach (stage_in[k]) begin
                n = words_in[s];
                row_ring[s][n % 32] = stage_in[k];
                words_in[s] = n + 1;
                while (words_out[s] < fr_total && words_out[s] + fr_wpr + 1 <= n) begin
                    stage_out.push_back(window_word(s, words_out[s]));
                    words_out[s]++;
                end
            end
            if (last) begin
                while (words_out[s] < fr_total) begin
                    stage_out.push_back(window_word(s, words_out[s]));
                    words_out[s]++;
                end
            end
            stage_in = stage_out;
        end
        foreach (stage_in[k]) begin
            res.word = stage_in[k];
            res.last = last && (k == stage_in.size() - 1);
            result_queue.push_back(res);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // input driver
    always @(posedge i_clk) begin
        t_pix_item it;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_words(in_ch.pixel_word, in_ch.frame_start);
                words_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap > 0 || pixel_queue.size() == 0) begin
                    if (in_gap > 0) in_gap--;
                    in_ch.valid <= 1'b0;
                end else begin
                    it = pixel_queue.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.pixel_word <= it.word;
                    in_ch.frame_start <= it.start;
                    in_gap = pick_gap();
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_res_item exp_res;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                words_checked++;
                if (result_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %h", out_ch.out_word));
                end else begin
                    exp_res = result_queue.pop_front();
                    if (out_ch.out_word !== exp_res.word)
                        report_mismatch($sformatf("out_word %h, expected %h",
                                                  out_ch.out_word, exp_res.word));
                    if (out_ch.out_last !== exp_res.last)
                        report_mismatch($sformatf("out_last %b, expected %b",
                                                  out_ch.out_last, exp_res.last));
                end
            end
            if (out_hold_cycles > 0) begin
                out_hold_cycles--;
                out_ch.ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                out_gap = pick_gap();
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_WIDTH:  reg_width = data;
            CFG_HEIGHT: reg_height = data;
            CFG_MODE:   reg_mode = data[MODE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() != 0 || in_ch.valid || result_queue.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [WORD_BITS-1:0] pick_word(int density);
        case (density)
            0: return $urandom() & $urandom() & $urandom();
            1: return $urandom() | $urandom() | $urandom();
            2: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic int frame_words();
        int unsigned w, h;
        w = reg_width;
        h = reg_height;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return ((w + WORD_BITS - 1) / WORD_BITS) * h;
    endfunction

    task automatic queue_words(input int count, input logic first_start);
        t_pix_item it;
        int density;
        density = $urandom_range(0, 3);
        for (int k = 0; k < count; k++) begin
            it.word = pick_word(density);
            it.start = (k == 0) ? first_start : 1'b0;
            pixel_queue.push_back(it);
        end
    endtask

    task automatic run_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic [DIM_W-1:0] m);
        logic cut;
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_MODE, m);
        no_idle = ($urandom_range(0, 4) == 0);
        cut = 1'b0;
        // now and then a partial frame that a new frame start cuts short
        if ($urandom_range(0, 9) == 0 && frame_words() > 2) begin
            queue_words($urandom_range(1, frame_words() - 1), 1'b1);
            cut = 1'b1;
        end
        queue_words(frame_words(), cut | 1'($urandom_range(0, 1)));
        frames_sent++;
        wait_drained();
    endtask

    initial begin
        t_pix_item it;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_WIDTH;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.pixel_word = '0;
        in_ch.frame_start = 1'b0;
        out_ch.ready = 1'b0;
        reg_width = RST_WIDTH;
        reg_height = RST_HEIGHT;
        reg_mode = MODE_OPEN_CLOSE;
        out_hold_cycles = 0;
        no_idle = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: tiny frames, saturated settings, every mode
        write_reg(CFG_WIDTH, 9'd1);
        write_reg(CFG_HEIGHT, 9'd1);
        write_reg(CFG_MODE, DIM_W'(MODE_ERODE));
        it.word = '1;
        it.start = 1'b1;
        pixel_queue.push_back(it);
        frames_sent++;
        wait_drained();
        write_reg(CFG_WIDTH, 9'd33);
        write_reg(CFG_HEIGHT, 9'd2);
        write_reg(CFG_MODE, DIM_W'(MODE_DILATE));
        it.start = 1'b1;
        it.word = 32'h8000_0001;
        pixel_queue.push_back(it);
        it.start = 1'b0;
        it.word = 32'hFFFF_FFFF;
        pixel_queue.push_back(it);
        it.word = 32'h0;
        pixel_queue.push_back(it);
        it.word = 32'hFFFF_FFFE;
        pixel_queue.push_back(it);
        frames_sent++;
        wait_drained();
        run_frame(9'd0, 9'd0, DIM_W'(MODE_CLOSE));
        run_frame(9'd5, 9'd3, DIM_W'(MODE_GRADIENT));
        run_frame(9'd511, 9'd1, 9'd5);
        run_frame(9'd40, 9'd2, 9'd6);
        run_frame(9'd7, 9'd2, 9'd7);
        run_frame(9'd32, 9'd3, DIM_W'(MODE_OPEN_CLOSE));

        // long receiver hold-off while a wide frame keeps coming
        write_reg(CFG_WIDTH, 9'd256);
        write_reg(CFG_HEIGHT, 9'd6);
        write_reg(CFG_MODE, DIM_W'(MODE_GRADIENT));
        out_hold_cycles = 250;
        no_idle = 1'b1;
        queue_words(frame_words(), 1'b1);
        frames_sent++;
        wait_drained();

        // tallest frame
        run_frame(9'd1, 9'd300, DIM_W'($urandom_range(0, 7)));

        while (words_sent < 460) begin
            if ($urandom_range(0, 7) == 0)
                run_frame(DIM_W'($urandom_range(0, 511)), DIM_W'($urandom_range(0, 4)),
                          DIM_W'($urandom_range(0, 7)));
            else
                run_frame(DIM_W'($urandom_range(1, 100)), DIM_W'($urandom_range(1, 6)),
                          DIM_W'($urandom_range(0, 7)));
        end

        wait_drained();
        if (result_queue.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", result_queue.size()));
        $display("covered %0d frames: %0d input words, %0d result words checked",
                 frames_sent, words_sent, words_checked);
        $display("all modes, width and height extremes, tail masking and dropped frames");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
